// ===== rtl/core/wmrq_pkg.sv =====
package wmrq_pkg;
    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_LEN + 1);
    localparam int ADR_W      = $clog2(MAX_LEN);
    localparam int LVL_W      = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_RANK  = 3'd1,
        OP_KTH   = 3'd2,
        OP_LESS  = 3'd3,
        OP_RFREQ = 3'd4,
        OP_PREV  = 3'd5,
        OP_NEXT  = 3'd6,
        OP_NONE  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_K     = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    // walk modes of one level cell
    typedef enum logic [1:0] {
        WK_EQ  = 2'd0,
        WK_LT  = 2'd1,
        WK_SEL = 2'd2
    } walk_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENC,
        S_BUILD,
        S_DIST,
        S_CHECK,
        S_WALK1,
        S_WALK2,
        S_WAIT,
        S_OUT
    } state_t;

    // word passed along the chain of level cells
    typedef struct packed {
        logic                  vld;
        walk_t                 mode;
        logic [IDX_W-1:0]      l;
        logic [IDX_W-1:0]      r;
        logic [IDX_W-1:0]      acc;
        logic [VALUE_BITS-1:0] key;
        logic [VALUE_BITS-1:0] res;
    } walk_word_t;
endpackage

// ===== rtl/core/wmrq_cell.sv =====
// one bit level: prefix-ones memory, zero count, walk step (registered prefix-count read, then the registered step)
module wmrq_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [wmrq_pkg::IDX_W-1:0]         wr_addr,
    input  logic [wmrq_pkg::IDX_W-1:0]         wr_data,
    input  logic                               zc_we,
    input  logic [wmrq_pkg::IDX_W-1:0]         zc_data,
    input  logic [wmrq_pkg::LVL_W-1:0]         lvl,
    input  wmrq_pkg::walk_word_t               w_in,
    output wmrq_pkg::walk_word_t               w_out
);
    import wmrq_pkg::*;

    logic [IDX_W-1:0] mem [0:MAX_LEN];
    logic [IDX_W-1:0] ol_reg, or_reg, zc_reg;
    walk_word_t       hold_reg;
    walk_word_t       out_reg;
    logic [IDX_W-1:0] zeros;
    logic             bit_y;
    walk_word_t       w_next;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (zc_we) zc_reg <= zc_data;
        ol_reg   <= mem[w_in.l];
        or_reg   <= mem[w_in.r];
        hold_reg <= w_in;
    end

    always_comb begin
        w_next = hold_reg;
        zeros  = (hold_reg.r - hold_reg.l) - (or_reg - ol_reg);
        bit_y  = hold_reg.key[lvl];
        if (hold_reg.mode == WK_SEL) bit_y = (hold_reg.acc >= zeros);
        if (bit_y) begin
            w_next.l = zc_reg + ol_reg;
            w_next.r = zc_reg + or_reg;
            w_next.res[lvl] = 1'b1;
            if (hold_reg.mode == WK_LT) w_next.acc = hold_reg.acc + zeros;
            if (hold_reg.mode == WK_SEL) w_next.acc = hold_reg.acc - zeros;
        end else begin
            w_next.l = hold_reg.l - ol_reg;
            w_next.r = hold_reg.r - or_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else begin
            out_reg <= w_next;
        end
    end

    assign w_out = out_reg;
endmodule

// ===== rtl/core/wavelet_matrix_range_query_core.sv =====
// Wavelet matrix over up to 1024 loaded 32-bit values. Load words (opcode 0)
// append elements and give no result. The word with tlast set starts the build:
// a pass of encoding, then two passes per level (prefix counts, then the stable
// partition). Queries walk a chain of 32 level cells; each level does a
// registered prefix-count read, then the step. Rank, kth and less_than need one
// walk. Range_freq, prev_value and next_value need two walks. A bad range or a
// bad k is answered in the cycle after the word is taken. One item is handled
// at a time; a new word is taken only when the output register is empty or is
// read in the same cycle.
module wavelet_matrix_range_query_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, value_a, value_b, left, right, k (zero filled to 104 bits)
    input  logic [103:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // count, value, status (zero filled to 48 bits)
    output logic [47:0]  m_tdata
);
    import wmrq_pkg::*;

    localparam int VB = VALUE_BITS;

    logic signed_reg;
    logic [VB-1:0] sflip;
    assign sflip = signed_reg ? {1'b1, {(VB-1){1'b0}}} : '0;

    state_t           st_reg, st_next;
    logic             loading_reg;
    logic [IDX_W-1:0] len_reg;
    logic [VB-1:0]    elem [0:2*MAX_LEN-1];
    logic             bank_reg;
    logic [IDX_W-1:0] i_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic [IDX_W-1:0] ones_reg, p0_reg, p1_reg;
    logic [VB-1:0]    rd_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_i_reg;
    logic [2:0]       op_reg;
    logic [VB-1:0]    a_reg, b_reg;
    logic [IDX_W-1:0] l_reg, r_reg, k_reg, first_reg;
    logic [47:0]      out_reg;
    logic             ov_reg;

    walk_word_t chain [0:VB];
    walk_word_t inj;

    logic [VB-1:0] in_a, in_b;
    logic [2:0]    in_op;
    assign in_op = s_tdata[2:0];
    assign in_a  = s_tdata[34:3];
    assign in_b  = s_tdata[66:35];

    assign s_tready = (st_reg == S_IDLE) && (!ov_reg || m_tready);
    logic acc_in;
    assign acc_in = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    // per-level write strobes
    logic             pw_en;
    logic [IDX_W-1:0] pw_addr, pw_data;
    logic             zc_we;

    genvar g;
    generate
        for (g = 0; g < VB; g++) begin : g_cell
            logic [LVL_W-1:0] lv;
            assign lv = LVL_W'(VB - 1 - g);
            wmrq_cell u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .wr_en(pw_en && lvl_reg == lv), .wr_addr(pw_addr), .wr_data(pw_data),
                .zc_we(zc_we && lvl_reg == lv), .zc_data(len_reg - ones_reg),
                .lvl(lv), .w_in(chain[g]), .w_out(chain[g+1]));
        end
    endgenerate
    assign chain[0] = inj;

    // build: read element i of current bank; S_DIST writes it to the other bank
    logic             cur_bit;
    assign cur_bit = rd_reg[lvl_reg];

    logic [ADR_W:0] rd_addr;
    assign rd_addr = {bank_reg, i_reg[ADR_W-1:0]};

    always_ff @(posedge aclk) begin
        rd_reg     <= elem[rd_addr];
        rd_i_reg   <= i_reg;
        if (acc_in && in_op == OP_LOAD && (!loading_reg ? 1'b1 : len_reg < IDX_W'(MAX_LEN)))
            elem[{1'b0, (loading_reg ? len_reg[ADR_W-1:0] : {ADR_W{1'b0}})}] <= in_a;
        else if (st_reg == S_ENC && rd_vld_reg)
            elem[{1'b0, rd_i_reg[ADR_W-1:0]}] <= rd_reg ^ sflip;
        else if (st_reg == S_DIST && rd_vld_reg)
            elem[{~bank_reg, (cur_bit ? p1_reg[ADR_W-1:0] : p0_reg[ADR_W-1:0])}] <= rd_reg;
    end

    logic finish;
    logic [VB-1:0]    val_w;
    logic [IDX_W-1:0] cnt_w;

    always_comb begin
        st_next = st_reg;
        pw_en = 1'b0; pw_addr = '0; pw_data = '0; zc_we = 1'b0;
        inj = '0;
        finish = 1'b0;
        case (st_reg)
            S_IDLE: ;
            S_ENC: if (rd_vld_reg && rd_i_reg == len_reg - 1'b1) st_next = S_BUILD;
            S_BUILD: begin
                // prefix ones: entry 0 first, then one per element read
                pw_en   = 1'b1;
                pw_addr = rd_vld_reg ? rd_i_reg + 1'b1 : '0;
                pw_data = rd_vld_reg ? ones_reg + IDX_W'(cur_bit) : '0;
                if (len_reg == '0 || (rd_vld_reg && rd_i_reg == len_reg - 1'b1))
                    st_next = S_DIST;
            end
            S_DIST: begin
                zc_we = 1'b1;
                if (len_reg == '0 || (rd_vld_reg && rd_i_reg == len_reg - 1'b1))
                    st_next = (lvl_reg == '0) ? S_IDLE : S_BUILD;
            end
            S_CHECK: begin
                inj.vld = 1'b1; inj.l = l_reg; inj.r = r_reg;
                case (op_reg)
                    OP_RANK: begin inj.mode = WK_EQ; inj.key = a_reg ^ sflip; end
                    OP_KTH:  begin inj.mode = WK_SEL; inj.acc = k_reg; end
                    default: begin inj.mode = WK_LT; inj.key = a_reg ^ sflip; end
                endcase
                st_next = S_WALK1;
            end
            S_WALK1: if (chain[VB].vld) begin
                if (op_reg == OP_RANK || op_reg == OP_KTH || op_reg == OP_LESS)
                    finish = 1'b1;
                else st_next = S_WAIT;
            end
            S_WAIT: begin
                inj.vld = 1'b1; inj.l = l_reg; inj.r = r_reg;
                if (op_reg == OP_RFREQ) begin
                    inj.mode = WK_LT; inj.key = b_reg ^ sflip;
                end else begin
                    inj.mode = WK_SEL;
                    inj.acc  = (op_reg == OP_PREV) ? first_reg - 1'b1 : first_reg;
                end
                st_next = S_WALK2;
            end
            S_WALK2: if (chain[VB].vld) finish = 1'b1;
            default: st_next = S_IDLE;
        endcase
        if (finish) st_next = S_IDLE;
        val_w = (chain[VB].res ^ sflip);
        cnt_w = '0;
        case (op_reg)
            OP_RANK: cnt_w = chain[VB].r - chain[VB].l;
            OP_LESS: cnt_w = chain[VB].acc;
            OP_RFREQ: cnt_w = (chain[VB].acc > first_reg) ? chain[VB].acc - first_reg : '0;
            default: cnt_w = '0;
        endcase
    end

    logic [IDX_W-1:0] qlen;
    assign qlen = IDX_W'(s_tdata[88:78]) - IDX_W'(s_tdata[77:67]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; loading_reg <= 1'b0; len_reg <= '0;
            signed_reg <= 1'b1; ov_reg <= 1'b0; rd_vld_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) signed_reg <= cfg_wdata;
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            if (acc_in) begin
                op_reg <= in_op; a_reg <= in_a; b_reg <= in_b;
                l_reg <= s_tdata[77:67]; r_reg <= s_tdata[88:78];
                k_reg <= IDX_W'(s_tdata[98:89]);
                if (in_op == OP_LOAD) begin
                    loading_reg <= !s_tlast;
                    if (!loading_reg) len_reg <= IDX_W'(1);
                    else if (len_reg < IDX_W'(MAX_LEN)) len_reg <= len_reg + 1'b1;
                    if (s_tlast) begin
                        st_reg <= S_ENC; i_reg <= '0; bank_reg <= 1'b0;
                        rd_vld_reg <= 1'b0;
                    end
                end else if (in_op != OP_NONE) begin
                    if (loading_reg || s_tdata[77:67] > s_tdata[88:78] ||
                        s_tdata[88:78] > len_reg) begin
                        out_reg <= {3'd0, ST_RANGE, 32'd0, 11'd0}; ov_reg <= 1'b1;
                    end else if (in_op == OP_KTH &&
                                 IDX_W'(s_tdata[98:89]) >= qlen) begin
                        out_reg <= {3'd0, ST_K, 32'd0, 11'd0}; ov_reg <= 1'b1;
                    end else st_reg <= S_CHECK;
                end
            end
            // build sequencing, and capture of the first walk's result
            case (st_reg)
                S_ENC: begin
                    if (i_reg < len_reg) begin
                        i_reg <= i_reg + 1'b1; rd_vld_reg <= 1'b1;
                    end
                    if (st_next == S_BUILD) begin
                        i_reg <= '0; lvl_reg <= LVL_W'(VB - 1); ones_reg <= '0;
                    end
                end
                S_BUILD: begin
                    if (i_reg < len_reg) begin
                        i_reg <= i_reg + 1'b1; rd_vld_reg <= 1'b1;
                    end
                    if (rd_vld_reg) ones_reg <= ones_reg + IDX_W'(cur_bit);
                    if (st_next == S_DIST) begin
                        i_reg <= '0; p0_reg <= '0;
                        p1_reg <= len_reg - (ones_reg + IDX_W'(rd_vld_reg & cur_bit));
                    end
                end
                S_DIST: begin
                    if (i_reg < len_reg) begin
                        i_reg <= i_reg + 1'b1; rd_vld_reg <= 1'b1;
                    end
                    if (rd_vld_reg) begin
                        if (cur_bit) p1_reg <= p1_reg + 1'b1;
                        else p0_reg <= p0_reg + 1'b1;
                    end
                    if (st_next != S_DIST) begin
                        bank_reg <= ~bank_reg; i_reg <= '0; ones_reg <= '0;
                        rd_vld_reg <= 1'b0;
                        lvl_reg <= lvl_reg - 1'b1;
                    end
                end
                S_WALK1: if (chain[VB].vld) first_reg <= chain[VB].acc;
                default: ;
            endcase
            if (finish) begin
                ov_reg <= 1'b1;
                case (op_reg)
                    OP_KTH: out_reg <= {3'd0, ST_OK, val_w, 11'd0};
                    OP_PREV: out_reg <= (first_reg == '0) ?
                        {3'd0, ST_NONE, 32'd0, 11'd0} : {3'd0, ST_OK, val_w, 11'd0};
                    OP_NEXT: out_reg <= (first_reg >= r_reg - l_reg) ?
                        {3'd0, ST_NONE, 32'd0, 11'd0} : {3'd0, ST_OK, val_w, 11'd0};
                    default: out_reg <= {3'd0, ST_OK, 32'd0, cnt_w};
                endcase
            end
        end
    end
endmodule

// ===== rtl/core/wmrq_checker.sv =====
module wmrq_sva (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import wmrq_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:45] == 3'd0)
        else $error("pad bits set");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[44:43] != ST_OK |-> m_tdata[42:0] == '0)
        else $error("error result carries data");

    // a waiting result holds off the input side
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result waits");
endmodule

bind wavelet_matrix_range_query_core wmrq_sva u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
